// ===== rtl/two_header_frame_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// two_header_frame_deframer_assert.svh
// assertion macros used by the deframer control module
// ----------------------------------------------------------------------------
`ifndef TWO_HEADER_FRAME_DEFRAMER_ASSERT_SVH
`define TWO_HEADER_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define THFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define THFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/thfd_pkg.sv =====
// ----------------------------------------------------------------------------
// thfd_pkg
// types and constants of the two-header frame deframer
// ----------------------------------------------------------------------------
package thfd_pkg;

  localparam int BYTE_W = 8;
  localparam int TMO_W  = 15;
  localparam int PH_W   = 2;
  localparam int HIDX_W = 2;
  localparam int CFG_AW = 2;

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] BODY_HDR_LEN = 8'd4;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_HEADER_FIRST   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HEADER_SECOND  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ESCAPE_TIMEOUT = 2'd2;
  localparam logic [CFG_AW-1:0] REG_DATA_TIMEOUT   = 2'd3;

  // register reset values
  localparam logic [BYTE_W-1:0] RST_HEADER_FIRST   = 8'd170;
  localparam logic [BYTE_W-1:0] RST_HEADER_SECOND  = 8'd85;
  localparam logic [TMO_W-1:0]  RST_ESCAPE_TIMEOUT = 15'd20;
  localparam logic [TMO_W-1:0]  RST_DATA_TIMEOUT   = 15'd5;

  // phase codes
  localparam logic [PH_W-1:0] PH_HUNT = 2'd0;
  localparam logic [PH_W-1:0] PH_HEAD = 2'd1;
  localparam logic [PH_W-1:0] PH_BODY = 2'd2;

  // input kind
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [TMO_W-1:0]  escape_timeout;
    logic [TMO_W-1:0]  data_timeout;
  } thfd_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_in_frame;
    logic              frame_start;
    logic              frame_end;
    logic              frame_abort;
    logic [BYTE_W-1:0] frame_length;
    logic              escape_kind;
  } thfd_result_t;

endpackage

// ===== rtl/thfd_cfg.sv =====
// ----------------------------------------------------------------------------
// thfd_cfg
// configuration register file of the deframer
// ----------------------------------------------------------------------------
module thfd_cfg
  import thfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [TMO_W-1:0]  cfg_wdata,
  output thfd_cfg_t         cfg
);

  thfd_cfg_t cfg_r;
  thfd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        REG_HEADER_FIRST:   cfg_nxt.header_first   = cfg_wdata[BYTE_W-1:0];
        REG_HEADER_SECOND:  cfg_nxt.header_second  = cfg_wdata[BYTE_W-1:0];
        REG_ESCAPE_TIMEOUT: cfg_nxt.escape_timeout = cfg_wdata;
        REG_DATA_TIMEOUT:   cfg_nxt.data_timeout   = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first   <= RST_HEADER_FIRST;
      cfg_r.header_second  <= RST_HEADER_SECOND;
      cfg_r.escape_timeout <= RST_ESCAPE_TIMEOUT;
      cfg_r.data_timeout   <= RST_DATA_TIMEOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/thfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// thfd_ctrl
// byte-wise frame state machine: hunt, header, body and per-byte timer
// ----------------------------------------------------------------------------
`include "two_header_frame_deframer_assert.svh"

module thfd_ctrl
  import thfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  thfd_cfg_t         cfg,
  input  logic              take,
  input  logic              mode,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              res_valid,
  output thfd_result_t      res
);

  logic [PH_W-1:0]   phase_r,     phase_nxt;
  logic              kind_r,      kind_nxt;
  logic [HIDX_W-1:0] hidx_r,      hidx_nxt;
  logic [BYTE_W-1:0] hlen_r,      hlen_nxt;
  logic [BYTE_W-1:0] total_r,     total_nxt;
  logic [BYTE_W-1:0] remain_r,    remain_nxt;
  logic [TMO_W-1:0]  wait_r,      wait_nxt;
  logic              bad_r,       bad_nxt;

  logic [TMO_W-1:0]  tick_cnt;
  logic [TMO_W-1:0]  load_val;
  logic              load_kind;
  logic [BYTE_W-1:0] sum;
  logic [BYTE_W-1:0] rem_new;
  logic [BYTE_W-1:0] rem_dec;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    hidx_nxt   = hidx_r;
    hlen_nxt   = hlen_r;
    total_nxt  = total_r;
    remain_nxt = remain_r;
    wait_nxt   = wait_r;
    bad_nxt    = bad_r;
    res_valid  = 1'b0;
    res        = '0;
    res.out_byte = rx_byte;

    tick_cnt  = (wait_r != '0) ? wait_r - TMO_W'(1) : wait_r;
    load_kind = kind_r;
    sum       = hlen_r + rx_byte;
    rem_new   = sum - BODY_HDR_LEN;
    rem_dec   = remain_r - BYTE_W'(1);

    if (phase_r == PH_HUNT && rx_byte == ESC_BYTE) begin
      load_kind = 1'b1;
    end else if (phase_r == PH_HUNT) begin
      load_kind = 1'b0;
    end
    load_val = load_kind ? cfg.escape_timeout : cfg.data_timeout;

    if (take) begin
      if (mode == MODE_TICK) begin
        if (phase_r != PH_HUNT) begin
          wait_nxt = tick_cnt;
          if (tick_cnt == '0) begin
            phase_nxt       = PH_HUNT;
            res_valid       = 1'b1;
            res.out_byte    = '0;
            res.frame_abort = 1'b1;
            res.escape_kind = kind_r;
          end
        end
      end else begin
        res_valid = 1'b1;
        case (phase_r)
          PH_HUNT: begin
            if (rx_byte == ESC_BYTE || rx_byte == cfg.header_first) begin
              kind_nxt          = load_kind;
              hidx_nxt          = 2'd0;
              bad_nxt           = 1'b0;
              wait_nxt          = load_val;
              phase_nxt         = (load_val == '0) ? PH_HUNT : PH_HEAD;
              res.byte_in_frame = 1'b1;
              res.frame_start   = 1'b1;
              res.frame_abort   = (load_val == '0);
              res.escape_kind   = load_kind;
            end
          end
          PH_HEAD: begin
            res.byte_in_frame = 1'b1;
            res.escape_kind   = kind_r;
            wait_nxt          = load_val;
            case (hidx_r)
              2'd0: begin
                bad_nxt  = kind_r ? (rx_byte != ESC_BYTE) : (rx_byte != cfg.header_second);
                hidx_nxt = 2'd1;
              end
              2'd1: begin
                hlen_nxt = rx_byte;
                hidx_nxt = 2'd2;
              end
              default: begin
                total_nxt = sum;
                hidx_nxt  = 2'd0;
                if (!bad_r) begin
                  remain_nxt = rem_new;
                end
              end
            endcase
            if (hidx_r == 2'd2 && (bad_r || rem_new == '0)) begin
              wait_nxt        = wait_r;
              phase_nxt       = PH_HUNT;
              res.frame_abort = 1'b1;
            end else if (load_val == '0) begin
              phase_nxt       = PH_HUNT;
              res.frame_abort = 1'b1;
            end else if (hidx_r == 2'd2) begin
              phase_nxt = PH_BODY;
            end
          end
          default: begin
            res.byte_in_frame = 1'b1;
            res.escape_kind   = kind_r;
            remain_nxt        = rem_dec;
            if (rem_dec == '0) begin
              phase_nxt        = PH_HUNT;
              res.frame_end    = 1'b1;
              res.frame_length = total_r;
            end else begin
              wait_nxt = load_val;
              if (load_val == '0) begin
                phase_nxt       = PH_HUNT;
                res.frame_abort = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      kind_r   <= 1'b0;
      hidx_r   <= '0;
      hlen_r   <= '0;
      total_r  <= '0;
      remain_r <= '0;
      wait_r   <= '0;
      bad_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      hidx_r   <= hidx_nxt;
      hlen_r   <= hlen_nxt;
      total_r  <= total_nxt;
      remain_r <= remain_nxt;
      wait_r   <= wait_nxt;
      bad_r    <= bad_nxt;
    end
  end

  `THFD_ASSERT_NOW(a_byte_gives_result, take && mode == MODE_BYTE, res_valid, "byte without result")
  `THFD_ASSERT_NOW(a_hunt_tick_silent, take && mode == MODE_TICK && phase_r == PH_HUNT, !res_valid, "tick while hunting gave a result")
  `THFD_ASSERT_NOW(a_end_not_abort, res_valid && res.frame_end, !res.frame_abort && res.byte_in_frame, "frame end and abort together")
  `THFD_ASSERT_NEXT(a_close_to_hunt, res_valid && (res.frame_end || res.frame_abort), phase_r == PH_HUNT, "frame closed but not hunting")

endmodule

// ===== rtl/thfd_oreg.sv =====
// ----------------------------------------------------------------------------
// thfd_oreg
// result register with stream handshake towards the sink
// ----------------------------------------------------------------------------
module thfd_oreg
  import thfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_valid,
  input  thfd_result_t res,
  output logic         free,
  output logic         out_tvalid,
  input  logic         out_tready,
  output thfd_result_t out_res
);

  logic         vld_r, vld_nxt;
  thfd_result_t res_r;

  assign free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (free) begin
      vld_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_res    = res_r;

endmodule

// ===== rtl/two_header_frame_deframer.sv =====
// out_tvalid rises in the cycle after an accepted byte or aborting tick
// throughput: one item per cycle while the sink does not stall; the result
// register frees itself on the same edge at which the sink takes its transfer
// ticks while hunting or that do not expire the byte timer give no result
// reset: synchronous active-low rst_n returns to hunting and loads the
// register defaults; no clearing pass
// ----------------------------------------------------------------------------
// two_header_frame_deframer
// byte-wise deframer for 0xff-headed and ordinary frames with byte timeout
// ----------------------------------------------------------------------------
module two_header_frame_deframer
  import thfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [TMO_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // rx_byte
  input  logic [0:0]        in_tuser,   // mode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // out_byte, frame_length
  output logic              out_tlast,  // frame_end
  output logic [3:0]        out_tuser   // byte_in_frame, frame_start, frame_abort, escape_kind
);

  thfd_cfg_t    cfg;
  thfd_result_t res;
  thfd_result_t out_res;
  logic         res_valid;
  logic         free;
  logic         take;

  assign in_tready = free;
  assign take      = in_tvalid && free;

  thfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  thfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .take      (take),
    .mode      (in_tuser[0]),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  thfd_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.frame_length, out_res.out_byte};
  assign out_tlast = out_res.frame_end;
  assign out_tuser = {out_res.escape_kind, out_res.frame_abort,
                      out_res.frame_start, out_res.byte_in_frame};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the two-header frame deframer: a queue-fed driver
// offers bytes and ticks, an internal deframer predicts every result and a
// monitor compares each output transfer with the oldest prediction, across
// several register settings with random gaps and sink stalls
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PRINT_MAX   = 50;

  localparam int unsigned PACE_FULL   = 0;
  localparam int unsigned PACE_RANDOM = 1;
  localparam int unsigned PACE_SPARSE = 2;

  localparam logic [8:0] TK = {MODE_TICK, 8'h00};

  typedef struct {
    logic        mode;
    logic [7:0]  data;
    int unsigned gap;
  } rx_item_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_wr_en  = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [TMO_W-1:0]  cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;   // rx_byte
  logic [0:0]        in_tuser   = '0;   // mode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;         // out_byte, frame_length
  logic              out_tlast;         // frame_end
  logic [3:0]        out_tuser;         // byte_in_frame, frame_start, frame_abort, escape_kind

  rx_item_t     item_q[$];
  thfd_result_t deframed_q[$];

  int unsigned tx_pace       = PACE_RANDOM;
  int unsigned rx_pace       = PACE_RANDOM;
  logic        long_hold_req = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned stall_left    = 0;
  int unsigned bytes_made    = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;

  // register copy and deframer state
  thfd_cfg_t regs = {RST_HEADER_FIRST, RST_HEADER_SECOND, RST_ESCAPE_TIMEOUT,
                     RST_DATA_TIMEOUT};
  logic [PH_W-1:0]   ph        = PH_HUNT;
  logic              esc_frame = 1'b0;
  logic [HIDX_W-1:0] hdr_idx   = '0;
  logic [7:0]        len_hi    = '0;
  logic [7:0]        len_total = '0;
  logic [7:0]        body_left = '0;
  logic [TMO_W-1:0]  tick_left = '0;
  logic              hdr_bad   = 1'b0;

  two_header_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #1ns clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(input int unsigned pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 16);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic bit arm_timer();
    tick_left = esc_frame ? regs.escape_timeout : regs.data_timeout;
    return tick_left != '0;
  endfunction

  // next deframer result for one accepted byte or tick; 0 when none is due
  function automatic bit deframe_step(input logic mode, input logic [7:0] b,
                                      output thfd_result_t r);
    r = '0;
    if (mode == MODE_TICK) begin
      if (ph == PH_HUNT) return 1'b0;
      if (tick_left != '0) tick_left = tick_left - 1'b1;
      if (tick_left == '0) begin
        ph = PH_HUNT;
        r.frame_abort = 1'b1;
        r.escape_kind = esc_frame;
        return 1'b1;
      end
      return 1'b0;
    end
    r.out_byte = b;
    case (ph)
      PH_HUNT: begin
        if (b == ESC_BYTE) esc_frame = 1'b1;
        else if (b == regs.header_first) esc_frame = 1'b0;
        else return 1'b1;
        ph = PH_HEAD;
        hdr_idx = '0;
        hdr_bad = 1'b0;
        r.byte_in_frame = 1'b1;
        r.frame_start = 1'b1;
        r.escape_kind = esc_frame;
        if (!arm_timer()) begin
          ph = PH_HUNT;
          r.frame_abort = 1'b1;
        end
        return 1'b1;
      end
      PH_HEAD: begin
        r.byte_in_frame = 1'b1;
        r.escape_kind = esc_frame;
        if (hdr_idx == 2'd0) begin
          hdr_bad = esc_frame ? (b != ESC_BYTE) : (b != regs.header_second);
          hdr_idx = 2'd1;
        end else if (hdr_idx == 2'd1) begin
          len_hi = b;
          hdr_idx = 2'd2;
        end else begin
          len_total = len_hi + b;
          hdr_idx = '0;
          if (hdr_bad) begin
            ph = PH_HUNT;
            r.frame_abort = 1'b1;
            return 1'b1;
          end
          body_left = len_total - BODY_HDR_LEN;
          if (body_left == 8'd0) begin
            ph = PH_HUNT;
            r.frame_abort = 1'b1;
            return 1'b1;
          end
          ph = PH_BODY;
        end
        if (!arm_timer()) begin
          ph = PH_HUNT;
          r.frame_abort = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        r.byte_in_frame = 1'b1;
        r.escape_kind = esc_frame;
        body_left = body_left - 8'd1;
        if (body_left == 8'd0) begin
          ph = PH_HUNT;
          r.frame_end = 1'b1;
          r.frame_length = len_total;
          return 1'b1;
        end
        if (!arm_timer()) begin
          ph = PH_HUNT;
          r.frame_abort = 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_MAX) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // driver: predicts on each accepted transfer, then offers the next item
  always @(posedge clk) begin : drive
    thfd_result_t r;
    rx_item_t     nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (deframe_step(in_tuser[0], in_tdata, r)) deframed_q.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        if (item_q.size() != 0 && item_q[0].gap != 0) begin
          item_q[0].gap = item_q[0].gap - 1;
          in_tvalid <= 1'b0;
        end else if (item_q.size() != 0) begin
          nxt = item_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tuser  <= nxt.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink readiness: short random stalls and one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      hold_left = 0;
      out_tready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      if (out_tvalid && out_tready) stall_left = draw_wait(rx_pace);
      else if (stall_left != 0) stall_left--;
      out_tready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin : monitor
    thfd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (deframed_q.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        want = deframed_q.pop_front();
        check_field("out_byte", out_tdata[7:0], want.out_byte);
        check_field("frame_length", out_tdata[15:8], want.frame_length);
        check_field("frame_end", 8'(out_tlast), 8'(want.frame_end));
        check_field("byte_in_frame", 8'(out_tuser[0]), 8'(want.byte_in_frame));
        check_field("frame_start", 8'(out_tuser[1]), 8'(want.frame_start));
        check_field("frame_abort", 8'(out_tuser[2]), 8'(want.frame_abort));
        check_field("escape_kind", 8'(out_tuser[3]), 8'(want.escape_kind));
      end
    end
  end

  task automatic push_item(input logic mode, input logic [7:0] b);
    rx_item_t it;
    it.mode = mode;
    it.data = (mode == MODE_TICK) ? 8'($urandom) : b;
    it.gap = draw_wait(tx_pace);
    item_q.push_back(it);
    if (mode == MODE_BYTE) bytes_made++;
  endtask

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_item(MODE_TICK, 8'h00);
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 2) == 0) push_item(MODE_TICK, 8'h00);
      else push_item(MODE_BYTE, 8'($urandom));
    end
  endtask

  // one frame with random content; broken frames are cut short by a
  // timeout or carry a wrong second header byte
  task automatic gen_frame(input bit broken, input int forced_total);
    bit          esc;
    bit          cut_short;
    int unsigned tmo;
    int unsigned total;
    int unsigned nbytes;
    int unsigned stop;
    int unsigned k;
    logic [7:0]  hdr1;
    logic [7:0]  hi_len;
    logic [7:0]  fb;
    esc = ($urandom_range(0, 1) == 1) || (regs.header_first == ESC_BYTE);
    hdr1 = esc ? ESC_BYTE : regs.header_second;
    tmo = esc ? regs.escape_timeout : regs.data_timeout;
    if (forced_total >= 0) total = forced_total;
    else if ($urandom_range(0, 9) == 0) total = 4;
    else total = $urandom_range(5, 16);
    nbytes = (total == 4) ? 4 : 4 + ((total - 4) & 255);
    cut_short = 1'b0;
    if (broken) begin
      if (tmo <= 64 && $urandom_range(0, 1) == 1) cut_short = 1'b1;
      else hdr1 = hdr1 ^ 8'($urandom_range(1, 255));
    end
    if (cut_short) stop = $urandom_range(1, nbytes - 1);
    else if (hdr1 != (esc ? ESC_BYTE : regs.header_second)) stop = 4;
    else stop = nbytes;
    hi_len = 8'($urandom);
    for (k = 0; k < stop; k++) begin
      case (k)
        0:       fb = esc ? ESC_BYTE : regs.header_first;
        1:       fb = hdr1;
        2:       fb = hi_len;
        3:       fb = total[7:0] - hi_len;
        default: fb = 8'($urandom);
      endcase
      if (k > 0 && tmo > 1 && $urandom_range(0, 3) == 0)
        push_ticks($urandom_range(1, (tmo > 6) ? 5 : tmo - 1));
      push_item(MODE_BYTE, fb);
    end
    if (cut_short) push_ticks(tmo + $urandom_range(0, 2));
  endtask

  task automatic run_random(input int unsigned n_bytes, input bit busy_start);
    int unsigned start;
    int unsigned r;
    start = bytes_made;
    while (bytes_made < start + n_bytes) begin
      if (busy_start && bytes_made < start + 60) tx_pace = PACE_FULL;
      else tx_pace = $urandom_range(PACE_FULL, PACE_SPARSE);
      r = $urandom_range(0, 99);
      if (r < 65) gen_frame(1'b0, -1);
      else if (r < 80) gen_noise();
      else gen_frame(1'b1, -1);
    end
  endtask

  // sender holds back until every transfer is offered and every result is in
  task automatic settle();
    while (item_q.size() != 0 || in_tvalid) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [TMO_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] hf, input logic [7:0] hs,
                          input logic [TMO_W-1:0] et, input logic [TMO_W-1:0] dt);
    write_reg(REG_HEADER_FIRST, {7'd0, hf});
    write_reg(REG_HEADER_SECOND, {7'd0, hs});
    write_reg(REG_ESCAPE_TIMEOUT, et);
    write_reg(REG_DATA_TIMEOUT, dt);
    regs = {hf, hs, et, dt};
  endtask

  initial begin
    logic [8:0] directed[];
    directed = '{
      9'h000, TK,
      9'h0FF, 9'h0FF, 9'h000, 9'h005, 9'h080,
      9'h0AA, 9'h055, 9'h001, 9'h003,
      9'h0AA, 9'h012, 9'h000, 9'h008,
      9'h0AA, TK, TK, TK, TK, TK,
      9'h0AA, 9'h055, TK, TK, 9'h000, 9'h005, TK, 9'h07F
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    foreach (directed[i]) push_item(directed[i][8], directed[i][7:0]);
    run_random(200, 1'b0);
    settle();

    set_regs(8'h00, 8'hFF, 15'd1, 15'd1);
    rx_pace = PACE_SPARSE;
    run_random(200, 1'b0);
    settle();

    // first header equal to the escape byte, widest timeouts, wrapped length
    set_regs(8'hFF, 8'h00, 15'h7FFF, 15'h7FFF);
    rx_pace = PACE_FULL;
    tx_pace = PACE_SPARSE;
    gen_frame(1'b0, 2);
    run_random(150, 1'b0);
    settle();

    // sink holds off while the source keeps offering
    set_regs(8'($urandom), 8'($urandom), 15'($urandom_range(2, 9)),
             15'($urandom_range(2, 9)));
    rx_pace = PACE_RANDOM;
    long_hold_req = 1'b1;
    run_random(200, 1'b1);
    settle();

    set_regs(8'h5A, 8'hA5, 15'd3, 15'd2);
    rx_pace = PACE_SPARSE;
    run_random(200, 1'b0);
    settle();

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && deframed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/thfd_pkg.sv
rtl/thfd_cfg.sv
rtl/thfd_ctrl.sv
rtl/thfd_oreg.sv
rtl/two_header_frame_deframer.sv
tb/tb.sv
